>>> hdl/kwd_pkg.sv
// Shared types and constants for the key-locked watchdog.
package kwd_pkg;

  localparam logic [31:0] FEED_KEY = 32'd1515870810;
  localparam logic [31:0] LOCK_KEY = 32'd449635665;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_kind_t;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_RELOAD  = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_STATUS  = 3'd3;
  localparam logic [2:0] REG_KEY     = 3'd4;

  localparam int CTRL_ENABLE = 0;
  localparam int CTRL_INTEN  = 1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } kwd_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        bad_register;
  } kwd_rsp_t;

endpackage

>>> hdl/kwd_if.sv
// Valid/ready channel interfaces for watchdog requests and responses.
interface kwd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  reg_index;
  logic [31:0] write_data;

  modport source (output valid, output req_type, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input reg_index, input write_data,
                output ready);
endinterface

interface kwd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;
  logic        bad_register;

  modport source (output valid, output read_data, output irq_level, output bad_register,
                  input ready);
  modport sink (input valid, input read_data, input irq_level, input bad_register,
                output ready);
endinterface

>>> hdl/kwd_core.sv
// Watchdog register state and the single-step update for one request.
module kwd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  kwd_pkg::kwd_req_t req,
  output kwd_pkg::kwd_rsp_t rsp
);
  import kwd_pkg::*;

  logic [1:0]  control_bits, control_bits_next;
  logic [31:0] reload_value, reload_value_next;
  logic [31:0] down_count, down_count_next;
  logic        timeout_flag, timeout_flag_next;
  logic        locked, locked_next;
  logic        idx_bad;
  logic [31:0] count_dec;

  assign idx_bad   = (req.reg_index > REG_KEY);
  assign count_dec = down_count - 32'd1;

  always_comb begin
    control_bits_next = control_bits;
    reload_value_next = reload_value;
    down_count_next   = down_count;
    timeout_flag_next = timeout_flag;
    locked_next       = locked;
    rsp.read_data     = '0;
    rsp.bad_register  = 1'b0;
    unique case (req_kind_t'(req.req_type))
      REQ_TICK: begin
        if (control_bits[CTRL_ENABLE] && (down_count != '0)) begin
          down_count_next = count_dec;
          if (count_dec == '0) timeout_flag_next = 1'b1;
        end
      end
      REQ_READ: begin
        rsp.bad_register = idx_bad;
        unique case (req.reg_index)
          REG_CONTROL: rsp.read_data = {30'd0, control_bits};
          REG_RELOAD:  rsp.read_data = reload_value;
          REG_COUNT:   rsp.read_data = down_count;
          REG_STATUS:  rsp.read_data = {31'd0, timeout_flag};
          default:     rsp.read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        rsp.bad_register = idx_bad;
        unique case (req.reg_index)
          REG_CONTROL: begin
            if (!locked) begin
              control_bits_next = req.write_data[1:0];
              // A rising edge of enable restarts the countdown.
              if (req.write_data[CTRL_ENABLE] && !control_bits[CTRL_ENABLE])
                down_count_next = reload_value;
            end
          end
          REG_RELOAD: begin
            if (!locked) reload_value_next = req.write_data;
          end
          REG_STATUS: begin
            if (req.write_data[0]) timeout_flag_next = 1'b0;
          end
          REG_KEY: begin
            if (!locked) begin
              if (req.write_data == FEED_KEY) begin
                down_count_next   = reload_value;
                timeout_flag_next = 1'b0;
              end else if (req.write_data == LOCK_KEY) begin
                locked_next = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.irq_level = timeout_flag_next & control_bits_next[CTRL_INTEN];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits <= '0;
      reload_value <= '0;
      down_count   <= '0;
      timeout_flag <= 1'b0;
      locked       <= 1'b0;
    end else if (step) begin
      control_bits <= control_bits_next;
      reload_value <= reload_value_next;
      down_count   <= down_count_next;
      timeout_flag <= timeout_flag_next;
      locked       <= locked_next;
    end
  end

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst) locked |=> locked)
    else $error("lock flag cleared without reset");
  a_locked_reload: assert property (@(posedge clk) disable iff (rst)
    locked |=> $stable(reload_value))
    else $error("reload value changed while locked");
  a_timeout_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(timeout_flag) |-> (down_count == '0))
    else $error("timeout flag set with nonzero count");
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(down_count) && $stable(control_bits))
    else $error("state changed without a request");
endmodule

>>> hdl/key_locked_watchdog.sv
// Top level of the key-locked watchdog: request register, core and response register.
//
// Usage: each request transaction on req is a tick (req_type 0), a register read (1)
// or a register write (2); type 3 is a no-op. Registers: 0 control (enable, irq
// enable), 1 reload, 2 count (read only), 3 status (write 1 clears timeout),
// 4 key (feed or lock key, reads 0). Every request produces exactly one response
// transaction on rsp with read_data, irq_level (state after the request) and
// bad_register for reads and writes to indexes 5 to 7.
// A request taken on req is held in the input register, then applied to the watchdog state
// at the same edge that loads its response into the response register, which makes it valid.
// Throughput is one request per cycle while the response register is free or being taken,
// as the core updates its state in a single step; req.ready stays high in that case.
// When the receiver stalls, the response holds, one more request waits in the input
// register, and then req.ready drops; state only advances as responses move out.
// Synchronous reset clears all watchdog state, including the lock, and empties both stages.
module key_locked_watchdog (
  input logic clk,
  input logic rst,
  kwd_req_if.sink   req,
  kwd_rsp_if.source rsp
);
  import kwd_pkg::*;

  kwd_req_t in_reg;
  logic     in_valid;
  kwd_rsp_t out_reg;
  logic     out_valid;
  kwd_rsp_t core_rsp;
  logic     advance;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  kwd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (in_reg),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) in_valid <= req.valid;
      if (advance) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_reg.req_type   <= req.req_type;
      in_reg.reg_index  <= req.reg_index;
      in_reg.write_data <= req.write_data;
    end
    if (advance) out_reg <= core_rsp;
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_reg.read_data;
  assign rsp.irq_level    = out_reg.irq_level;
  assign rsp.bad_register = out_reg.bad_register;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |-> !advance)
    else $error("response overwritten while stalled");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_reg))
    else $error("pending request lost");
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("response stage not loaded");
endmodule
